// ===== src/rtts_pkg.sv =====
// ----------------------------------------------------------------------------
// rtts_pkg
// Shared constants, types and helpers for the round-trip statistics core.
// ----------------------------------------------------------------------------
package rtts_pkg;

  localparam int COUNT_W  = 16;
  localparam int RTT_W    = 24;
  localparam int FRAC_W   = 8;
  localparam int MEAN_W   = RTT_W + FRAC_W;
  localparam int DEV_W    = 32;
  localparam int STAMP_W  = 64;
  localparam int DP_W     = 64;
  localparam int LOSS_W   = 7;
  localparam int PERCENT  = 100;
  // (sent - received) * 100 needs seven more bits than a count.
  localparam int NUM_W    = COUNT_W + 7;
  localparam int STEP_W   = $clog2(DP_W + 1);

  localparam int IN_DATA_W  = 2 * STAMP_W;
  // All result fields add up to 176 bits, a whole number of bytes.
  localparam int OUT_DATA_W = 2 * COUNT_W + LOSS_W + 1 + 3 * RTT_W + MEAN_W + DEV_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [RTT_W-1:0]   RTT_MAX   = '1;

  localparam logic [0:0] OP_SENT     = 1'b0;
  localparam logic [0:0] OP_RECEIVED = 1'b1;

  // Modes of the shared step unit.
  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_DIV  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_SQRT = 3'd4;

  typedef logic [DP_W-1:0] dp_word_t;

  typedef struct packed {
    dp_word_t acc;
    dp_word_t sh;
    dp_word_t opd;
  } rtts_dp_t;

  function automatic logic [MEAN_W-1:0] abs_diff(input logic [MEAN_W-1:0] a,
                                                  input logic [MEAN_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== src/rtts_step_unit.sv =====
// ----------------------------------------------------------------------------
// rtts_step_unit
// The single 64-bit adder of the core and the per-mode operand and update
// selection around it: a sum or difference, or one bit of a restoring division,
// one bit of a shift-and-add product or one two-bit square root digit per cycle.
// ----------------------------------------------------------------------------
module rtts_step_unit (
  input  logic [2:0]               mode,
  input  rtts_pkg::rtts_dp_t       cur,
  input  rtts_pkg::dp_word_t       ext_p,
  input  rtts_pkg::dp_word_t       ext_q,
  output rtts_pkg::rtts_dp_t       nxt,
  output rtts_pkg::dp_word_t       res,
  output logic                     carry
);
  import rtts_pkg::*;

  dp_word_t        p;
  dp_word_t        q;
  logic            sub;
  logic [DP_W:0]   sum;

  always_comb begin
    p   = ext_p;
    q   = ext_q;
    sub = 1'b0;
    case (mode)
      MODE_ADD: begin
        sub = 1'b0;
      end
      MODE_SUB: begin
        sub = 1'b1;
      end
      MODE_DIV: begin
        p   = {cur.acc[DP_W-2:0], cur.sh[DP_W-1]};
        q   = cur.opd;
        sub = 1'b1;
      end
      MODE_MUL: begin
        p   = {cur.acc[DP_W-2:0], 1'b0};
        q   = cur.sh[DP_W-1] ? cur.opd : '0;
      end
      MODE_SQRT: begin
        p   = {cur.acc[DP_W-3:0], cur.sh[DP_W-1:DP_W-2]};
        q   = {cur.opd[DP_W-3:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase

    // With subtraction the carry out is set when p >= q.
    sum   = {1'b0, p} + {1'b0, (sub ? ~q : q)} + {{DP_W{1'b0}}, sub};
    res   = sum[DP_W-1:0];
    carry = sum[DP_W];

    nxt = cur;
    case (mode)
      MODE_DIV: begin
        nxt.acc = carry ? res : p;
        nxt.sh  = {cur.sh[DP_W-2:0], carry};
      end
      MODE_MUL: begin
        nxt.acc = res;
        nxt.sh  = {cur.sh[DP_W-2:0], 1'b0};
      end
      MODE_SQRT: begin
        nxt.acc = carry ? res : p;
        nxt.opd = {cur.opd[DP_W-2:0], carry};
        nxt.sh  = {cur.sh[DP_W-3:0], 2'b00};
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== src/rtt_running_statistics_core.sv =====
// ----------------------------------------------------------------------------
// rtt_running_statistics_core
// Round-trip statistics for echo probes: counts, loss percentage, minimum,
// maximum, running mean and standard deviation of the round trips.
// ----------------------------------------------------------------------------
// A reply word runs the mean division, product, variance division and square root,
// then the loss division; a sent word runs only the loss division, which is skipped
// when nothing is lost. The next word is taken in the cycle after the result is loaded,
// later while a previous result still waits for out_tready. The shared adder in
// rtts_step_unit gives one quotient bit, product bit or root digit a cycle.
// Synchronous active-low reset clears counts and statistics.
module rtt_running_statistics_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // send_stamp [63:0], receive_stamp [127:64]
  input  logic [rtts_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation [0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // sent_total [15:0], received_total [31:16], loss_percent [38:32],
  // has_samples [39], last_rtt [63:40], min_rtt [87:64], max_rtt [111:88],
  // mean_rtt [143:112], deviation_rtt [175:144]
  output logic [rtts_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import rtts_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_EVT       = 4'd1;
  localparam logic [3:0] ST_MEAN      = 4'd2;
  localparam logic [3:0] ST_RUN       = 4'd3;
  localparam logic [3:0] ST_MEAN_DONE = 4'd4;
  localparam logic [3:0] ST_MUL       = 4'd5;
  localparam logic [3:0] ST_MUL_DONE  = 4'd6;
  localparam logic [3:0] ST_VAR       = 4'd7;
  localparam logic [3:0] ST_SQRT      = 4'd8;
  localparam logic [3:0] ST_SQRT_DONE = 4'd9;
  localparam logic [3:0] ST_LOSS      = 4'd10;
  localparam logic [3:0] ST_LOSS_DONE = 4'd11;
  localparam logic [3:0] ST_OUT       = 4'd12;

  logic [3:0]            state_r, state_nxt;
  logic [3:0]            ret_r, ret_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic [2:0]            mode_r, mode_nxt;
  rtts_dp_t              dp_r, dp_nxt;

  logic                  op_r;
  logic [STAMP_W-1:0]    send_r;
  logic [STAMP_W-1:0]    recv_r;

  logic [COUNT_W-1:0]    sent_r, sent_nxt;
  logic [COUNT_W-1:0]    rcvd_r, rcvd_nxt;
  logic [RTT_W-1:0]      min_r, min_nxt;
  logic [RTT_W-1:0]      max_r, max_nxt;
  logic [MEAN_W-1:0]     mean_r, mean_nxt;
  logic [MEAN_W-1:0]     old_mean_r, old_mean_nxt;
  logic                  ge_r, ge_nxt;
  dp_word_t              sum_r, sum_nxt;
  logic [DEV_W-1:0]      dev_r, dev_nxt;
  logic [RTT_W-1:0]      rtt_r, rtt_nxt;
  logic [LOSS_W-1:0]     loss_r, loss_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [2:0]            alu_mode;
  dp_word_t              alu_p, alu_q, alu_res;
  logic                  alu_carry;
  rtts_dp_t              step_nxt;

  logic [MEAN_W-1:0]     x_val;
  logic [RTT_W-1:0]      rtt_c;
  logic [NUM_W-1:0]      loss_num;
  logic                  has_samples;
  logic                  in_accept;

  assign in_tready   = (state_r == ST_IDLE);
  assign in_accept   = in_tvalid && in_tready;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign x_val       = {rtt_r, {FRAC_W{1'b0}}};
  assign has_samples = (rcvd_r != '0);
  assign loss_num    = NUM_W'(sent_r - rcvd_r) * NUM_W'(PERCENT);

  // The round trip comes from the shared adder while the event is decoded.
  assign rtt_c = !alu_carry ? '0 :
                 (alu_res[DP_W-1:RTT_W] != '0) ? RTT_MAX : alu_res[RTT_W-1:0];

  always_comb begin
    alu_mode = MODE_ADD;
    alu_p    = '0;
    alu_q    = '0;
    case (state_r)
      ST_RUN: begin
        alu_mode = mode_r;
      end
      ST_EVT: begin
        alu_mode = MODE_SUB;
        alu_p    = recv_r;
        alu_q    = send_r;
      end
      ST_MEAN_DONE: begin
        alu_mode = ge_r ? MODE_ADD : MODE_SUB;
        alu_p    = DP_W'(mean_r);
        alu_q    = DP_W'(dp_r.sh[MEAN_W-1:0]);
      end
      ST_MUL_DONE: begin
        alu_mode = MODE_ADD;
        alu_p    = sum_r;
        alu_q    = dp_r.acc;
      end
      default: begin
        alu_mode = MODE_ADD;
      end
    endcase
  end

  rtts_step_unit u_step (
    .mode  (alu_mode),
    .cur   (dp_r),
    .ext_p (alu_p),
    .ext_q (alu_q),
    .nxt   (step_nxt),
    .res   (alu_res),
    .carry (alu_carry)
  );

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    dp_nxt        = dp_r;
    sent_nxt      = sent_r;
    rcvd_nxt      = rcvd_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    mean_nxt      = mean_r;
    old_mean_nxt  = old_mean_r;
    ge_nxt        = ge_r;
    sum_nxt       = sum_r;
    dev_nxt       = dev_r;
    rtt_nxt       = rtt_r;
    loss_nxt      = loss_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EVT;
        end
      end
      ST_EVT: begin
        if (op_r == OP_RECEIVED) begin
          rtt_nxt = rtt_c;
          if (rcvd_r != COUNT_MAX) begin
            rcvd_nxt = rcvd_r + 1'b1;
          end
          if (!has_samples || rtt_c < min_r) begin
            min_nxt = rtt_c;
          end
          if (rtt_c > max_r) begin
            max_nxt = rtt_c;
          end
          state_nxt = ST_MEAN;
        end else begin
          rtt_nxt = '0;
          if (sent_r != COUNT_MAX) begin
            sent_nxt = sent_r + 1'b1;
          end
          state_nxt = ST_LOSS;
        end
      end
      ST_MEAN: begin
        old_mean_nxt = mean_r;
        ge_nxt       = (x_val >= mean_r);
        dp_nxt.acc   = '0;
        dp_nxt.sh    = {abs_diff(x_val, mean_r), {(DP_W-MEAN_W){1'b0}}};
        dp_nxt.opd   = DP_W'(rcvd_r);
        mode_nxt     = MODE_DIV;
        cnt_nxt      = STEP_W'(MEAN_W);
        ret_nxt      = ST_MEAN_DONE;
        state_nxt    = ST_RUN;
      end
      ST_RUN: begin
        dp_nxt  = step_nxt;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          state_nxt = ret_r;
        end
      end
      ST_MEAN_DONE: begin
        mean_nxt  = alu_res[MEAN_W-1:0];
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        dp_nxt.acc = '0;
        dp_nxt.sh  = {abs_diff(x_val, old_mean_r), {(DP_W-MEAN_W){1'b0}}};
        dp_nxt.opd = DP_W'(abs_diff(x_val, mean_r));
        mode_nxt   = MODE_MUL;
        cnt_nxt    = STEP_W'(MEAN_W);
        ret_nxt    = ST_MUL_DONE;
        state_nxt  = ST_RUN;
      end
      ST_MUL_DONE: begin
        sum_nxt   = alu_carry ? '1 : alu_res;
        state_nxt = ST_VAR;
      end
      ST_VAR: begin
        dp_nxt.acc = '0;
        dp_nxt.sh  = sum_r;
        dp_nxt.opd = DP_W'(rcvd_r);
        mode_nxt   = MODE_DIV;
        cnt_nxt    = STEP_W'(DP_W);
        ret_nxt    = ST_SQRT;
        state_nxt  = ST_RUN;
      end
      ST_SQRT: begin
        // The quotient left in the shift register is the radicand.
        dp_nxt.acc = '0;
        dp_nxt.opd = '0;
        mode_nxt   = MODE_SQRT;
        cnt_nxt    = STEP_W'(DP_W / 2);
        ret_nxt    = ST_SQRT_DONE;
        state_nxt  = ST_RUN;
      end
      ST_SQRT_DONE: begin
        dev_nxt   = dp_r.opd[DEV_W-1:0];
        state_nxt = ST_LOSS;
      end
      ST_LOSS: begin
        if (sent_r != '0 && sent_r > rcvd_r) begin
          dp_nxt.acc = '0;
          dp_nxt.sh  = {loss_num, {(DP_W-NUM_W){1'b0}}};
          dp_nxt.opd = DP_W'(sent_r);
          mode_nxt   = MODE_DIV;
          cnt_nxt    = STEP_W'(NUM_W);
          ret_nxt    = ST_LOSS_DONE;
          state_nxt  = ST_RUN;
        end else begin
          loss_nxt  = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_LOSS_DONE: begin
        loss_nxt  = dp_r.sh[LOSS_W-1:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {dev_r, mean_r, max_r,
                           (has_samples ? min_r : {RTT_W{1'b0}}),
                           rtt_r, has_samples, loss_r, rcvd_r, sent_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      cnt_r       <= '0;
      mode_r      <= MODE_ADD;
      out_valid_r <= 1'b0;
      sent_r      <= '0;
      rcvd_r      <= '0;
      min_r       <= RTT_MAX;
      max_r       <= '0;
      mean_r      <= '0;
      sum_r       <= '0;
      dev_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
      rcvd_r      <= rcvd_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      mean_r      <= mean_nxt;
      sum_r       <= sum_nxt;
      dev_r       <= dev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_tuser;
      send_r <= in_tdata[STAMP_W-1:0];
      recv_r <= in_tdata[IN_DATA_W-1:STAMP_W];
    end
    dp_r       <= dp_nxt;
    old_mean_r <= old_mean_nxt;
    ge_r       <= ge_nxt;
    rtt_r      <= rtt_nxt;
    loss_r     <= loss_nxt;
    out_data_r <= out_data_nxt;
  end

  // The loss figure never exceeds one hundred per cent.
  a_loss_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[2*COUNT_W +: LOSS_W] <= LOSS_W'(PERCENT)))
    else $error("loss percentage out of range");

  // Once samples exist the minimum never lies above the maximum.
  a_min_max : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && has_samples) |-> (min_r <= max_r))
    else $error("minimum above maximum");

  // The running mean stays within the range of the samples.
  a_mean_hull : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && has_samples) |->
      (mean_r >= {min_r, {FRAC_W{1'b0}}} && mean_r <= {max_r, {FRAC_W{1'b0}}}))
    else $error("mean outside sample range");

  // An iteration run always has steps left to do.
  a_run_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r != '0))
    else $error("iteration run with zero count");

  // A word is only accepted once the previous result has been loaded.
  a_accept_after_out : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> $past(state_r == ST_OUT || state_r == ST_IDLE))
    else $error("word accepted while busy");

endmodule
